@@ rtl/ilm_pkg.sv @@
// ----------------------------------------------------------------------------
// ilm_pkg : shared types and constants of the idle-loop CPU load monitor
// Widths, configuration register indexes, sequencer states and the
// status struct from the divider to the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package ilm_pkg;

  // Idle pass counter width
  localparam int CNT_W      = 32;
  localparam int TICK_W     = 32;
  localparam int WIN_W      = 16;
  localparam int FS_W       = 21;
  localparam int PCT_W      = 7;

  // Percent arithmetic: ((F - L) << 11) / (20 * F)
  localparam int PCT_SHIFT  = 11;
  localparam int PCT_MAX    = 100;
  localparam int NUM_W      = FS_W + PCT_SHIFT;
  localparam int DEN_W      = FS_W + 5;              // 20 * F < 2^(FS_W+5)
  localparam int Q_W        = 7;                     // quotient never above 102
  localparam int DSOR_W     = DEN_W + Q_W - 1;
  localparam int DIFF_W     = ((NUM_W > DSOR_W) ? NUM_W : DSOR_W) + 1;
  localparam int STEP_W     = $clog2(Q_W);
  localparam int CMP_W      = (CNT_W > FS_W) ? CNT_W : FS_W;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = FS_W;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_PREDIVIDE  = CFG_IDX_W'(2);

  localparam logic [WIN_W-1:0] WINDOW_RST     = WIN_W'(100);
  localparam logic [FS_W-1:0]  FULL_SCALE_RST = FS_W'(1);

  // Item operations
  localparam logic OP_IDLE  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_OUT
  } ilm_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ilm_div_stat_t;

endpackage

`default_nettype wire

@@ rtl/ilm_divider.sv @@
// ----------------------------------------------------------------------------
// ilm_divider : iterative restoring divider
// One compare/subtract unit, one quotient bit per cycle, Q_W bits a start.
// ----------------------------------------------------------------------------
`default_nettype none

module ilm_divider (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [ilm_pkg::NUM_W-1:0] num,
  input  wire logic [ilm_pkg::DEN_W-1:0] den,
  output ilm_pkg::ilm_div_stat_t         stat,
  output logic [ilm_pkg::Q_W-1:0]        quot
);
  import ilm_pkg::*;

  logic [NUM_W-1:0]  rem_r,  rem_nxt;
  logic [DSOR_W-1:0] dsor_r, dsor_nxt;
  logic [Q_W-1:0]    quot_r, quot_nxt;
  logic [STEP_W-1:0] cnt_r,  cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DIFF_W-1:0] diff;
  logic              ge;

  // shared subtractor: trial remainder minus shifted divisor
  assign diff = DIFF_W'(rem_r) - DIFF_W'(dsor_r);
  assign ge   = ~diff[DIFF_W-1];

  always_comb begin
    rem_nxt  = rem_r;
    dsor_nxt = dsor_r;
    quot_nxt = quot_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = num;
      dsor_nxt = DSOR_W'(den) << (Q_W - 1);
      quot_nxt = '0;
      cnt_nxt  = STEP_W'(Q_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (ge) begin
        rem_nxt = diff[NUM_W-1:0];
      end
      quot_nxt = {quot_r[Q_W-2:0], ge};
      dsor_nxt = dsor_r >> 1;
      cnt_nxt  = cnt_r - STEP_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    dsor_r <= dsor_nxt;
    quot_r <= quot_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = quot_r;

endmodule

`default_nettype wire

@@ rtl/idle_loop_cpu_load_monitor_unit.sv @@
// ----------------------------------------------------------------------------
// idle_loop_cpu_load_monitor_unit : CPU load from idle-loop pass counts
// Counts idle passes per tick window and turns the last window's count
// into a usage percentage on request.
// ----------------------------------------------------------------------------
// An idle pass transfer (op 0) returns nothing; the block is ready
// again on the next cycle. A query transfer (op 1) returns one
// usage_percent result and keeps in_stall high after it while the
// sequencer runs ST_DIV and ST_OUT: the shared restoring divider works
// one quotient bit per cycle, its registered done flag moves the
// sequencer to ST_OUT, and ST_OUT hands the result to the output
// register, so the next item is taken only back in ST_IDLE, later if
// that register is still held by a stalled earlier result. Windows are
// measured on now_ticks with wrap-safe signed comparisons; window_ticks,
// full_scale_loops and predivide_on are written over the cfg_ port, which
// is always ready and should only be used while no query is in flight.
`default_nettype none

module idle_loop_cpu_load_monitor_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // item channel
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_op,
  input  wire logic [31:0]                    in_now_ticks,
  // result channel
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [6:0]                          out_usage_percent,
  // configuration writes
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [ilm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ilm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ilm_pkg::*;

  // configuration
  logic [WIN_W-1:0]  window_r;
  logic [FS_W-1:0]   full_scale_r;
  logic              predivide_r;

  // measurement state
  logic [CNT_W-1:0]  idle_count_r,  idle_count_nxt;
  logic [CNT_W-1:0]  latched_r,     latched_nxt;
  logic [TICK_W-1:0] deadline_r,    deadline_nxt;

  // sequencer
  ilm_state_t        state_r, state_nxt;
  logic              div_start;
  logic              out_load;
  logic              out_valid_r;
  logic [PCT_W-1:0]  pct_r;

  // datapath
  logic              in_xfer;
  logic [TICK_W-1:0] win_ext;
  logic [TICK_W-1:0] new_deadline;
  logic [TICK_W-1:0] dl_diff;
  logic [TICK_W-1:0] stale_diff;
  logic              now_after_dl;
  logic              now_stale;
  logic [CNT_W-1:0]  loops;
  logic [FS_W-1:0]   fs;
  logic              loops_over;
  logic [FS_W-1:0]   fs_minus;
  logic [NUM_W-1:0]  div_num;
  logic [DEN_W-1:0]  div_den;
  ilm_div_stat_t     div_stat;
  logic [Q_W-1:0]    div_quot;
  logic [PCT_W-1:0]  pct_clamped;

  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r     <= WINDOW_RST;
      full_scale_r <= FULL_SCALE_RST;
      predivide_r  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WINDOW:     window_r     <= cfg_data[WIN_W-1:0];
        REG_FULL_SCALE: full_scale_r <= cfg_data[FS_W-1:0];
        REG_PREDIVIDE:  predivide_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // wrap-safe time tests: t after d when (d - t) is negative
  assign win_ext      = TICK_W'(window_r);
  assign new_deadline = in_now_ticks + win_ext;
  assign dl_diff      = deadline_r - in_now_ticks;
  assign stale_diff   = deadline_r + win_ext - in_now_ticks;
  assign now_after_dl = dl_diff[TICK_W-1];
  assign now_stale    = stale_diff[TICK_W-1];

  always_comb begin
    idle_count_nxt = idle_count_r;
    latched_nxt    = latched_r;
    deadline_nxt   = deadline_r;
    if (in_xfer) begin
      if (in_op == OP_IDLE) begin
        if (now_after_dl) begin
          latched_nxt    = idle_count_r;
          deadline_nxt   = new_deadline;
          idle_count_nxt = '0;
        end else begin
          idle_count_nxt = idle_count_r + CNT_W'(1);
        end
      end else if (now_stale) begin
        deadline_nxt   = new_deadline;
        idle_count_nxt = '0;
        latched_nxt    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_count_r <= '0;
      latched_r    <= '0;
      deadline_r   <= '0;
    end else begin
      idle_count_r <= idle_count_nxt;
      latched_r    <= latched_nxt;
      deadline_r   <= deadline_nxt;
    end
  end

  // percent operands from the count latched before this query
  assign loops      = predivide_r ? (latched_r >> PCT_SHIFT) : latched_r;
  assign fs         = (full_scale_r == '0) ? FS_W'(1) : full_scale_r;
  assign loops_over = CMP_W'(loops) > CMP_W'(fs);
  assign fs_minus   = fs - loops[FS_W-1:0];
  assign div_num    = loops_over ? '0 : {fs_minus, {PCT_SHIFT{1'b0}}};
  // 20 * F as two shifted adds
  assign div_den    = (DEN_W'(fs) << 4) + (DEN_W'(fs) << 2);

  ilm_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .stat  (div_stat),
    .quot  (div_quot)
  );

  assign pct_clamped = (div_quot > Q_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : PCT_W'(div_quot);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    out_load  = 1'b0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && in_op == OP_QUERY) begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output register: frees the sequencer while a result waits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      pct_r <= pct_clamped;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_usage_percent = pct_r;

endmodule

`default_nettype wire

@@ rtl/ilm_checker.sv @@
// ----------------------------------------------------------------------------
// ilm_checker : port-level assertions for the CPU load monitor
// Watches the top level's ports only; attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module ilm_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       in_op,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [6:0] out_usage_percent,
  input wire logic       cfg_ready
);
  import ilm_pkg::*;

  // a result never reads above full load
  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_usage_percent <= 7'(PCT_MAX)))
    else $error("usage_percent above 100");

  // a query transfer holds off the next item
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_op == OP_QUERY) |=> in_stall)
    else $error("item taken while a query is in flight");

  // a fresh result only appears while the input side is held off
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_valid) && $past(rst_n)) |-> $past(in_stall))
    else $error("result without a query in flight");

  // a stalled result is held
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_usage_percent)))
    else $error("stalled result dropped or changed");

  // configuration writes never wait
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("configuration port not ready");

endmodule

bind idle_loop_cpu_load_monitor_unit ilm_checker u_ilm_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .in_op             (in_op),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_usage_percent (out_usage_percent),
  .cfg_ready         (cfg_ready)
);

`default_nettype wire

@@ test/idle_loop_cpu_load_monitor_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idle_loop_cpu_load_monitor_unit_tb : self-checking bench for the load monitor
// Walks a short directed table of idle passes, queries and register writes,
// then runs random windowed traffic with a few set-piece episodes. Each
// usage_percent transfer is checked against a hand-typed table value or an
// in-bench predictor of the window counter and the percentage arithmetic.
// ----------------------------------------------------------------------------
module idle_loop_cpu_load_monitor_unit_tb;
  import ilm_pkg::*;

  localparam int N_RANDOM       = 1000;  // random items outside set pieces
  localparam int CALM_ITEMS     = 100;   // tail of the run without idling
  localparam int SETTLE_CYCLES  = 16;    // room for a last item still in flight
  localparam int DRAIN_CYCLES   = 32;
  localparam int LONG_HOLD      = 400;   // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 4000;  // cycles without any transfer
  localparam int PCT_DIV        = 20;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_t;

  // One line of the directed table: either an item or a register write.
  // Where known is set, pct is the result typed in by hand.
  typedef struct packed {
    row_kind_t             kind;
    logic                  op;
    logic [TICK_W-1:0]     now;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic                  known;
    logic [PCT_W-1:0]      pct;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_op;
  logic [31:0]           in_now_ticks;
  logic                  out_valid;
  logic                  out_stall;
  logic [6:0]            out_usage_percent;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Predictor state and its copy of the registers
  logic [CNT_W-1:0]  m_count;
  logic [CNT_W-1:0]  m_latched;
  logic [TICK_W-1:0] m_deadline;
  logic [WIN_W-1:0]  m_win;
  logic [FS_W-1:0]   m_fs;
  logic              m_pre;

  logic [PCT_W-1:0] usage_q[$];   // usage results still to arrive
  logic [PCT_W-1:0] want_pct;
  dir_row_t         dir_tbl[$];

  int  n_fail;
  int  n_items;
  int  n_queries;
  int  n_writes;
  int  n_results;
  int  quiet_cycles;
  bit  calm;       // no idling on either side
  bit  steady;     // sender offers back to back
  bit  hold_req;   // ask the receiver for one long hold-off

  idle_loop_cpu_load_monitor_unit u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_now_ticks      (in_now_ticks),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_usage_percent (out_usage_percent),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Wrap-safe "t is after d": the distance d - t, read as signed, is negative.
  function automatic bit tick_later(input logic [TICK_W-1:0] t,
                                    input logic [TICK_W-1:0] d);
    logic [TICK_W-1:0] gap;
    gap = d - t;
    return gap[TICK_W-1];
  endfunction

  task automatic predict_usage(input logic op, input logic [TICK_W-1:0] now,
                               output bit has_res, output logic [PCT_W-1:0] pct);
    longint unsigned lv;
    longint unsigned fv;
    longint unsigned pv;
    has_res = 1'b0;
    pct     = '0;
    if (op == OP_IDLE) begin
      // window closed: latch the count and open the next window
      if (tick_later(now, m_deadline)) begin
        m_latched  = m_count;
        m_deadline = now + TICK_W'(m_win);
        m_count    = '0;
      end else begin
        m_count = m_count + CNT_W'(1);
      end
    end else begin
      // the result always uses the latched count from before this query
      lv = 64'(m_latched);
      if (tick_later(now, m_deadline + TICK_W'(m_win))) begin
        // stale measurement: restart, but the old value is still reported
        m_deadline = now + TICK_W'(m_win);
        m_count    = '0;
        m_latched  = '0;
      end
      if (m_pre)
        lv = lv >> PCT_SHIFT;
      fv = (m_fs == '0) ? 64'd1 : 64'(m_fs);   // zero full scale reads as one
      if (lv > fv) begin
        pv = 0;
      end else begin
        pv = ((fv - lv) << PCT_SHIFT) / fv / PCT_DIV;
        if (pv > PCT_MAX)
          pv = PCT_MAX;
      end
      has_res = 1'b1;
      pct     = pv[PCT_W-1:0];
    end
  endtask

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------

  task automatic idle_input(input int cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Offers one item and holds it until the transfer; the expectation is
  // queued at the accepting edge. valid stays high for a following item.
  task automatic send_item(input logic op, input logic [TICK_W-1:0] now,
                           input bit fixed, input logic [PCT_W-1:0] fixed_pct);
    bit               has_res;
    logic [PCT_W-1:0] pct;
    @(negedge clk);
    in_valid     <= 1'b1;
    in_op        <= op;
    in_now_ticks <= now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_usage(op, now, has_res, pct);
    if (has_res) begin
      usage_q.push_back(fixed ? fixed_pct : pct);
      n_queries++;
    end
    n_items++;
    if (!calm && !steady && $urandom_range(0, 3) == 0)
      idle_input($urandom_range(1, 6));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_WINDOW:     m_win = data[WIN_W-1:0];
      REG_FULL_SCALE: m_fs  = data[FS_W-1:0];
      REG_PREDIVIDE:  m_pre = data[0];
      default: ;      // unknown index: the write is dropped
    endcase
    n_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stop offering, let every outstanding result arrive, then allow for a
  // last idle pass or query still being worked on.
  task automatic settle_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (usage_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic reconfigure();
    logic [WIN_W-1:0] w;
    logic [FS_W-1:0]  fs;
    int               span;
    settle_block();
    case ($urandom_range(0, 9))
      0:       w = '0;
      1:       w = '1;
      2:       w = WIN_W'($urandom_range(9, 300));
      default: w = WIN_W'($urandom_range(1, 8));
    endcase
    // roughly one idle pass per tick, so keep the full scale near the count
    span = (w > 300) ? 300 : int'(w);
    case ($urandom_range(0, 7))
      0:       fs = '0;
      1:       fs = FS_W'($urandom());
      2:       fs = '1;
      default: fs = FS_W'($urandom_range(1, 2 * span + 4));
    endcase
    // upper data bits above each register's width must be ignored
    write_reg(REG_WINDOW, {5'($urandom()), w});
    write_reg(REG_FULL_SCALE, fs);
    write_reg(REG_PREDIVIDE, {20'($urandom()), 1'($urandom_range(0, 3) == 0)});
    if ($urandom_range(0, 3) == 0)
      write_reg(REG_UNUSED, CFG_DATA_W'($urandom()));
  endtask

  // Mostly well-formed traffic: time creeps forward from the current
  // deadline, with the odd jump past a stale window and a little noise.
  task automatic run_episode(input int len);
    logic [TICK_W-1:0] t;
    logic [TICK_W-1:0] now;
    logic              op;
    int                k;
    t = m_deadline + TICK_W'($urandom_range(0, 4)) - TICK_W'(2);
    for (k = 0; k < len; k++) begin
      if ($urandom_range(0, 19) == 0) begin
        op  = 1'($urandom());
        now = $urandom();
      end else begin
        if ($urandom_range(0, 19) == 0)
          t = t + TICK_W'(m_win) + TICK_W'($urandom_range(1, int'(m_win) + 4));
        else
          t = t + TICK_W'($urandom_range(0, 2));
        op  = ($urandom_range(0, 7) == 0) ? OP_QUERY : OP_IDLE;
        now = t;
      end
      send_item(op, now, 1'b0, '0);
    end
  endtask

  // One window holding more than 2048 passes, so that the predivided
  // count is non-zero against a tiny full scale.
  task automatic dense_window();
    logic [TICK_W-1:0] t;
    int                n;
    int                k;
    settle_block();
    write_reg(REG_WINDOW, CFG_DATA_W'(8));
    write_reg(REG_FULL_SCALE, CFG_DATA_W'($urandom_range(1, 3)));
    write_reg(REG_PREDIVIDE, CFG_DATA_W'(1));
    // stale query restarts the window at t
    t = m_deadline + TICK_W'(9) + TICK_W'($urandom_range(0, 3));
    send_item(OP_QUERY, t, 1'b0, '0);
    n = $urandom_range(2100, 5000);
    for (k = 0; k < n; k++)
      send_item(OP_IDLE, t, 1'b0, '0);
    send_item(OP_IDLE, t + TICK_W'(9), 1'b0, '0);
    send_item(OP_QUERY, t + TICK_W'(10), 1'b0, '0);
    send_item(OP_QUERY, t + TICK_W'(11), 1'b0, '0);
  endtask

  function automatic void add_item(input logic op, input logic [TICK_W-1:0] now,
                                   input logic known, input logic [PCT_W-1:0] pct);
    dir_row_t r;
    r       = '0;
    r.kind  = ROW_ITEM;
    r.op    = op;
    r.now   = now;
    r.known = known;
    r.pct   = pct;
    dir_tbl.push_back(r);
  endfunction

  function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
    dir_row_t r;
    r      = '0;
    r.kind = ROW_CFG;
    r.idx  = idx;
    r.data = data;
    dir_tbl.push_back(r);
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int  n_rand;
    int  len;
    int  k;
    bit  in_cfg;
    bit  hold_done;
    bit  dense_done;
    bit  pause_done;

    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_op        = OP_IDLE;
    in_now_ticks = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    m_count      = '0;
    m_latched    = '0;
    m_deadline   = '0;
    m_win        = WINDOW_RST;
    m_fs         = FULL_SCALE_RST;
    m_pre        = 1'b0;
    n_fail       = 0;
    n_items      = 0;
    n_queries    = 0;
    n_writes     = 0;
    n_results    = 0;
    calm         = 1'b0;
    steady       = 1'b0;
    hold_req     = 1'b0;
    n_rand       = 0;
    in_cfg       = 1'b0;
    hold_done    = 1'b0;
    dense_done   = 1'b0;
    pause_done   = 1'b0;

    // Reset registers: window 100, full scale 1, no predivide.
    // No idle pass at all reads as full load.
    add_item(OP_QUERY, 32'd0, 1'b1, 7'd100);
    add_item(OP_IDLE,  32'd0, 1'b0, '0);        // not after deadline 0: count
    add_item(OP_IDLE,  32'd1, 1'b0, '0);        // closes, latches one pass
    add_item(OP_QUERY, 32'd5, 1'b1, 7'd0);      // count equals full scale
    add_item(OP_IDLE,  32'd6, 1'b0, '0);
    add_item(OP_IDLE,  32'd7, 1'b0, '0);
    add_item(OP_IDLE,  32'd102, 1'b0, '0);      // latches two passes
    add_item(OP_QUERY, 32'd103, 1'b1, 7'd0);    // count above full scale
    add_item(OP_QUERY, 32'd500, 1'b1, 7'd0);    // stale, old value reported
    add_item(OP_QUERY, 32'd501, 1'b1, 7'd100);  // cleared by the stale query
    // zero window, zero full scale, predivide on
    add_cfg(REG_WINDOW, '0);
    add_cfg(REG_FULL_SCALE, '0);
    add_cfg(REG_PREDIVIDE, CFG_DATA_W'(1));
    add_item(OP_IDLE,  32'hFFFF_FFFF, 1'b0, '0); // just before zero: not after
    add_item(OP_IDLE,  32'd601, 1'b0, '0);
    add_item(OP_IDLE,  32'd601, 1'b0, '0);
    add_item(OP_QUERY, 32'd601, 1'b1, 7'd100);   // one pass shifts down to zero
    add_item(OP_QUERY, 32'h8000_0259, 1'b0, '0); // half the tick range away
    // register extremes, masked upper bits, unknown register index
    add_cfg(REG_WINDOW, '1);
    add_cfg(REG_FULL_SCALE, '1);
    add_cfg(REG_PREDIVIDE, CFG_DATA_W'('1) - CFG_DATA_W'(1));
    add_cfg(REG_UNUSED, '1);
    add_item(OP_IDLE,  32'h8000_0259, 1'b0, '0);
    add_item(OP_IDLE,  32'h8000_025A, 1'b0, '0);
    add_item(OP_QUERY, 32'h8000_025B, 1'b0, '0);
    add_item(OP_QUERY, 32'd0, 1'b0, '0);
    // mid-range percentage
    add_cfg(REG_WINDOW, CFG_DATA_W'(3));
    add_cfg(REG_FULL_SCALE, CFG_DATA_W'(4));
    add_cfg(REG_PREDIVIDE, '0);
    add_item(OP_IDLE,  32'h0001_0000, 1'b0, '0);
    add_item(OP_IDLE,  32'h0001_0001, 1'b0, '0);
    add_item(OP_IDLE,  32'h0001_0002, 1'b0, '0);
    add_item(OP_IDLE,  32'h0001_0003, 1'b0, '0);
    add_item(OP_IDLE,  32'h0001_0004, 1'b0, '0);
    add_item(OP_QUERY, 32'h0001_0005, 1'b0, '0);
    add_item(OP_QUERY, 32'h0001_0010, 1'b0, '0);

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].kind == ROW_CFG) begin
        if (!in_cfg)
          settle_block();
        in_cfg = 1'b1;
        write_reg(dir_tbl[i].idx, dir_tbl[i].data);
      end else begin
        in_cfg = 1'b0;
        send_item(dir_tbl[i].op, dir_tbl[i].now, dir_tbl[i].known, dir_tbl[i].pct);
      end
    end

    while (n_rand < N_RANDOM) begin
      if (n_rand >= N_RANDOM - CALM_ITEMS)
        calm = 1'b1;
      if (!calm && $urandom_range(0, 3) == 0)
        reconfigure();
      if (!hold_done && n_rand >= 150) begin
        // receiver holds off while queries keep coming: the output register
        // and the divider fill and the block stalls its input
        hold_done = 1'b1;
        hold_req  = 1'b1;
        steady    = 1'b1;
        for (k = 0; k < 6; k++)
          send_item(OP_QUERY, m_deadline + TICK_W'(k), 1'b0, '0);
        steady = 1'b0;
      end
      if (!dense_done && n_rand >= 300) begin
        dense_done = 1'b1;
        dense_window();
      end
      if (!pause_done && n_rand >= 600) begin
        pause_done = 1'b1;
        settle_block();
      end
      len = $urandom_range(20, 60);
      if (n_rand + len > N_RANDOM)
        len = N_RANDOM - n_rand;
      run_episode(len);
      n_rand += len;
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (usage_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items (%0d queries) and %0d register writes over several settings,",
             n_items, n_queries, n_writes);
    $display("checked %0d usage results, %0d mismatches.", n_results, n_fail);
    if (n_fail == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver side: random stall bursts, one long hold-off on request,
  // none in the calm tail.
  // --------------------------------------------------------------------------
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(0, 5)) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Result check: every transfer against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (usage_q.size() == 0) begin
        $display("%0t: unexpected usage_percent transfer, expected none, actual %0d",
                 $time, out_usage_percent);
        n_fail++;
      end else begin
        want_pct = usage_q.pop_front();
        if (out_usage_percent !== want_pct) begin
          $display("%0t: usage_percent mismatch, expected %0d, actual %0d",
                   $time, want_pct, out_usage_percent);
          n_fail++;
        end
        n_results++;
      end
    end
  end

  // Watchdog: too long without a transfer on any channel ends the run
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, usage_q.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial quiet_cycles = 0;

endmodule
